FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define U2B_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define U2B_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define U2B_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/u2b_pkg.sv
package u2b_pkg;

   localparam int BYTE_W          = 8;
   localparam int UNIT_W          = 16;
   localparam int CP_W            = 21;
   localparam int CHAR_W          = 7;
   localparam int SEXTET_W        = 6;
   localparam int BUF_W           = 21;
   localparam int BUF_CNT_W       = 5;
   localparam int HELD_MAX        = 3;
   localparam int UNITS_MAX       = 3;
   localparam int UCNT_W          = 2;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam logic [2:0] LEAD_BAD   = 3'd0;
   localparam logic [2:0] LEAD_ASCII = 3'd1;
   localparam logic [2:0] LEAD_TWO   = 3'd2;
   localparam logic [2:0] LEAD_THREE = 3'd3;
   localparam logic [2:0] LEAD_FOUR  = 3'd4;

   localparam logic [UNIT_W-1:0] REPL_UNIT = 16'hFFFD;
   localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
   localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;
   localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
   localparam logic [CHAR_W-1:0] PAD_CHAR  = 7'h3D;

   typedef struct packed {
      logic [UNIT_W-1:0] unit;
      logic              last;
   } u2b_unit_type;

   function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [2:0] len;
      priority if (b[7] == 1'b0) len = LEAD_ASCII;
      else if (b[7:5] == 3'b110) len = LEAD_TWO;
      else if (b[7:4] == 4'b1110) len = LEAD_THREE;
      else if (b[7:3] == 5'b11110) len = LEAD_FOUR;
      else len = LEAD_BAD;
      return len;
   endfunction

   function automatic logic [CP_W-1:0] join_two(input logic [BYTE_W-1:0] b0,
                                                input logic [BYTE_W-1:0] b1);
      return {10'b0, b0[4:0], b1[5:0]};
   endfunction

   function automatic logic [CP_W-1:0] join_three(input logic [BYTE_W-1:0] b0,
                                                  input logic [BYTE_W-1:0] b1,
                                                  input logic [BYTE_W-1:0] b2);
      return {5'b0, b0[3:0], b1[5:0], b2[5:0]};
   endfunction

   function automatic logic [CP_W-1:0] join_four(input logic [BYTE_W-1:0] b0,
                                                 input logic [BYTE_W-1:0] b1,
                                                 input logic [BYTE_W-1:0] b2,
                                                 input logic [BYTE_W-1:0] b3);
      return {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
   endfunction

   function automatic logic [CHAR_W-1:0] b64_char(input logic [SEXTET_W-1:0] idx);
      logic [CHAR_W-1:0] wide;
      logic [CHAR_W-1:0] c;
      wide = {1'b0, idx};
      priority if (idx < 6'd26) c = wide + 7'd65;
      else if (idx < 6'd52) c = wide + 7'd71;
      else if (idx < 6'd62) c = wide - 7'd4;
      else if (idx == 6'd62) c = 7'd43;
      else c = 7'd47;
      return c;
   endfunction

endpackage

FILE: rtl/u2b_req_if.sv
interface u2b_req_if import u2b_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   logic              is_last;

   modport source (output valid, in_byte, is_last, input ready);
   modport sink (input valid, in_byte, is_last, output ready);
endinterface

FILE: rtl/u2b_rsp_if.sv
interface u2b_rsp_if import u2b_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              out_last;

   modport source (output valid, out_char, out_last, input ready);
   modport sink (input valid, out_char, out_last, output ready);
endinterface

FILE: rtl/u2b_queue.sv
module u2b_queue import u2b_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  u2b_unit_type push_entry,
   output logic         pop_valid,
   input  logic         pop_ready,
   output u2b_unit_type pop_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   u2b_unit_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push;
   logic              pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/u2b_front.sv
`include "assert_macros.svh"

module u2b_front import u2b_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   u2b_req_if.sink      req_ch,
   output logic         push_valid,
   input  logic         push_ready,
   output u2b_unit_type push_entry
);

   logic [HELD_MAX-1:0][BYTE_W-1:0]   held_ff, held_in;
   logic [1:0]                        hcnt_ff, hcnt_in;
   logic [2:0]                        need_ff, need_in;
   logic [UNITS_MAX-1:0][UNIT_W-1:0]  unit_ff, unit_in;
   logic [UCNT_W-1:0]                 ucnt_ff, ucnt_in;
   logic                              ulast_ff, ulast_in;

   logic [2:0]                        lead_len;
   logic [1:0]                        dec_hcnt;
   logic                              have_cp;
   logic [CP_W-1:0]                   cp;
   logic [CP_W-1:0]                   cp_off;
   logic [2:0]                        len_one;
   logic                              pair_taken;
   logic [UNITS_MAX-1:0][UNIT_W-1:0]  new_units;
   logic [UCNT_W-1:0]                 new_n;
   logic                              accept;
   logic                              push;

   assign push          = (ucnt_ff != '0) && push_ready;
   assign push_valid    = (ucnt_ff != '0);
   assign push_entry    = '{unit: unit_ff[0], last: ulast_ff && (ucnt_ff == 2'd1)};
   assign req_ch.ready  = (ucnt_ff == '0) || ((ucnt_ff == 2'd1) && push);
   assign accept        = req_ch.valid && req_ch.ready;

   // decode one byte against the held sequence
   always_comb begin
      lead_len = lead_length(req_ch.in_byte);
      held_in  = held_ff;
      dec_hcnt = hcnt_ff;
      need_in  = need_ff;
      have_cp  = 1'b0;
      cp       = '0;
      if (hcnt_ff == 2'd0) begin
         priority if (lead_len == LEAD_ASCII) begin
            have_cp = 1'b1;
            cp      = {13'b0, req_ch.in_byte};
         end else if (lead_len == LEAD_BAD) begin
            have_cp = 1'b1;
            cp      = {5'b0, REPL_UNIT};
         end else begin
            held_in[0] = req_ch.in_byte;
            dec_hcnt   = 2'd1;
            need_in    = lead_len;
         end
      end else if ((3'(hcnt_ff) + 3'd1) == need_ff) begin
         have_cp  = 1'b1;
         dec_hcnt = 2'd0;
         unique case (need_ff)
            LEAD_TWO:   cp = join_two(held_ff[0], req_ch.in_byte);
            LEAD_THREE: cp = join_three(held_ff[0], held_ff[1], req_ch.in_byte);
            default:    cp = join_four(held_ff[0], held_ff[1], held_ff[2], req_ch.in_byte);
         endcase
      end else begin
         unique case (hcnt_ff)
            2'd1:    held_in[1] = req_ch.in_byte;
            default: held_in[2] = req_ch.in_byte;
         endcase
         dec_hcnt = hcnt_ff + 2'd1;
      end
      hcnt_in = dec_hcnt;
      if (req_ch.is_last) begin
         hcnt_in = 2'd0;
         need_in = 3'd0;
      end
   end

   // turn the code point, or the cut-short tail, into UTF-16 units
   always_comb begin
      cp_off     = cp - SUPP_BASE;
      len_one    = lead_length(held_in[1]);
      pair_taken = 1'b0;
      new_units  = '0;
      new_n      = '0;
      if (have_cp) begin
         if (cp >= SUPP_BASE) begin
            new_units[0] = HI_SURR + {5'b0, cp_off[20:10]};
            new_units[1] = LO_SURR + {6'b0, cp_off[9:0]};
            new_n        = 2'd2;
         end else begin
            new_units[0] = cp[UNIT_W-1:0];
            new_n        = 2'd1;
         end
      end else if (req_ch.is_last && (dec_hcnt != 2'd0)) begin
         new_units[0] = REPL_UNIT;
         new_n        = 2'd1;
         if (dec_hcnt >= 2'd2) begin
            priority if (len_one == LEAD_ASCII) begin
               new_units[1] = {8'b0, held_in[1]};
            end else if ((len_one == LEAD_TWO) && (dec_hcnt == 2'd3)) begin
               new_units[1] = UNIT_W'(join_two(held_in[1], held_in[2]));
               pair_taken   = 1'b1;
            end else begin
               new_units[1] = REPL_UNIT;
            end
            new_n = 2'd2;
            if ((dec_hcnt == 2'd3) && !pair_taken) begin
               new_units[2] = (lead_length(held_in[2]) == LEAD_ASCII) ?
                              {8'b0, held_in[2]} : REPL_UNIT;
               new_n        = 2'd3;
            end
         end
      end
   end

   always_comb begin
      unit_in  = unit_ff;
      ucnt_in  = ucnt_ff;
      ulast_in = ulast_ff;
      if (accept) begin
         unit_in  = new_units;
         ucnt_in  = new_n;
         ulast_in = req_ch.is_last;
      end else if (push) begin
         unit_in[0] = unit_ff[1];
         unit_in[1] = unit_ff[2];
         ucnt_in    = ucnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff  <= '0;
         need_ff  <= '0;
         ucnt_ff  <= '0;
         ulast_ff <= 1'b0;
      end else begin
         if (accept) begin
            hcnt_ff <= hcnt_in;
            need_ff <= need_in;
         end
         ucnt_ff  <= ucnt_in;
         ulast_ff <= ulast_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff <= held_in;
      end
      unit_ff <= unit_in;
   end

   `U2B_ASSERT_IMPLY(a_held_below_len, clock, reset, hcnt_ff != 2'd0, need_ff > 3'(hcnt_ff), "held count reached sequence length")
   `U2B_ASSERT_NEXT(a_last_gives_unit, clock, reset, accept && req_ch.is_last, ucnt_ff != '0 && hcnt_ff == 2'd0, "final byte left no unit or a held sequence")

endmodule

FILE: rtl/u2b_back.sv
`include "assert_macros.svh"

module u2b_back import u2b_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         pop_valid,
   output logic         pop_ready,
   input  u2b_unit_type pop_entry,
   u2b_rsp_if.source    rsp_ch
);

   localparam logic [BUF_CNT_W-1:0] SEXTET_CNT = BUF_CNT_W'(SEXTET_W);
   localparam logic [BUF_CNT_W-1:0] UNIT_CNT   = BUF_CNT_W'(UNIT_W);

   logic [BUF_W-1:0]      bits_ff, bits_in;
   logic [BUF_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  lastp_ff, lastp_in;
   logic [1:0]            mod_ff, mod_in;
   logic                  ov_ff, ov_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  olast_ff, olast_in;

   logic                  slot_free;
   logic                  have_full;
   logic                  emit_full;
   logic                  emit_part;
   logic                  emit_pad;
   logic                  emit;
   logic                  emit_final;
   logic [BUF_CNT_W-1:0]  cnt_left;
   logic [1:0]            mod_next;
   logic                  pop;
   logic [BUF_W-1:0]      shifted;
   logic [UNIT_W-1:0]     le_bytes;

   assign slot_free  = !ov_ff || rsp_ch.ready;
   assign have_full  = (cnt_ff >= SEXTET_CNT);
   assign emit_full  = slot_free && have_full;
   assign emit_part  = slot_free && lastp_ff && !have_full && (cnt_ff != '0);
   assign emit_pad   = slot_free && lastp_ff && (cnt_ff == '0) && (mod_ff != 2'd0);
   assign emit       = emit_full || emit_part || emit_pad;
   assign mod_next   = mod_ff + 2'd1;
   assign cnt_left   = emit_full ? (cnt_ff - SEXTET_CNT) : (emit_part ? '0 : cnt_ff);
   assign emit_final = emit && lastp_ff && (cnt_left == '0) && (mod_next == 2'd0);
   assign pop_ready  = !lastp_ff && (cnt_left < SEXTET_CNT);
   assign pop        = pop_valid && pop_ready;
   assign le_bytes   = {pop_entry.unit[7:0], pop_entry.unit[15:8]};
   assign shifted    = (emit_full || emit_part) ? (bits_ff << SEXTET_W) : bits_ff;

   always_comb begin
      bits_in  = shifted;
      cnt_in   = cnt_left;
      lastp_in = lastp_ff;
      mod_in   = emit ? mod_next : mod_ff;
      if (pop) begin
         bits_in  = shifted | ({le_bytes, {(BUF_W - UNIT_W){1'b0}}} >> cnt_left);
         cnt_in   = cnt_left + UNIT_CNT;
         lastp_in = pop_entry.last;
      end else if (emit_final) begin
         lastp_in = 1'b0;
      end
   end

   always_comb begin
      ov_in    = ov_ff;
      char_in  = char_ff;
      olast_in = olast_ff;
      if (emit) begin
         ov_in    = 1'b1;
         char_in  = emit_pad ? PAD_CHAR : b64_char(bits_ff[BUF_W-1 -: SEXTET_W]);
         olast_in = emit_final;
      end else if (rsp_ch.ready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bits_ff  <= '0;
         cnt_ff   <= '0;
         lastp_ff <= 1'b0;
         mod_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         bits_ff  <= bits_in;
         cnt_ff   <= cnt_in;
         lastp_ff <= lastp_in;
         mod_ff   <= mod_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      olast_ff <= olast_in;
   end

   assign rsp_ch.valid    = ov_ff;
   assign rsp_ch.out_char = char_ff;
   assign rsp_ch.out_last = olast_ff;

   `U2B_ASSERT_ALWAYS(a_buf_bound, clock, reset, cnt_ff <= BUF_CNT_W'(BUF_W), "bit buffer overflow")
   `U2B_ASSERT_ALWAYS(a_buf_clean, clock, reset, (bits_ff << cnt_ff) == '0, "stale bits below buffer fill")
   `U2B_ASSERT_NEXT(a_final_clears, clock, reset, emit_final, cnt_ff == '0 && mod_ff == 2'd0 && !lastp_ff, "encoder not idle after final character")

endmodule

FILE: rtl/utf8_to_utf16le_base64_encoder.sv
// channel   dir  fields               transaction
// req_ch    in   in_byte, is_last     one UTF-8 byte, is_last on the final byte
// rsp_ch    out  out_char, out_last   one Base64 character, out_last on the final one
//
// Front side takes one byte a cycle while it yields at most one UTF-16 unit;
// a surrogate pair or a cut-short tail, or a full unit queue, holds it back.
// Back side shifts 16 bits per unit out as 6-bit digits, one character a
// cycle through the output register while rsp_ch.ready is high.
// Reset is synchronous and clears all counters at once; no clearing pass.
// rsp_ch.ready low holds the character; the unit queue absorbs front/back skew.
module utf8_to_utf16le_base64_encoder import u2b_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   u2b_req_if.sink     req_ch,
   u2b_rsp_if.source   rsp_ch
);

   logic         push_valid;
   logic         push_ready;
   u2b_unit_type push_entry;
   logic         pop_valid;
   logic         pop_ready;
   u2b_unit_type pop_entry;

   u2b_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   u2b_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   u2b_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_ch    (rsp_ch)
   );

endmodule
